/* sv/rrt_pkg.sv */
// Shared types and constants for the received range tracker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rrt_pkg;

	// Storage and field widths
	localparam int MAX_RANGES  = 16;
	localparam int OFFSET_BITS = 48;
	localparam int LENGTH_BITS = 32;
	localparam int CNT_BITS    = $clog2(MAX_RANGES + 1);
	localparam int COUNT_BITS  = 5;
	localparam int SUM_BITS    = ((OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS) + 1;

	// Operation codes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_RAISE = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [CNT_BITS-1:0]    count_t;

	// What one cell hands to its right neighbor
	typedef struct packed {
		offset_t rbegin;
		offset_t rend;
		logic    below;
		logic    above;
		logic    hit_seen;
	} cell_link_t;

	// Command broadcast from the controller to every cell
	typedef struct packed {
		logic    remove;
		logic    insert;
		offset_t new_begin;
		offset_t new_end;
	} cell_cmd_t;

endpackage : rrt_pkg

`default_nettype wire

/* sv/rrt_cell.sv */
// One slot of the sorted range table: holds a range, classifies it against
// the working range and shifts with its neighbors. Depends on rrt_pkg.
`default_nettype none

module rrt_cell import rrt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       cell_valid,
	input  wire cell_cmd_t  cmd,
	input  wire cell_link_t left,
	input  wire offset_t    right_begin,
	input  wire offset_t    right_end,
	output cell_link_t      link,
	output logic            first_hit
);

	offset_t rbegin_q;
	offset_t rend_q;
	logic    my_hit;
	logic    my_below;
	logic    my_above;
	logic    hit_incl;

	// Classify the stored range against the working range
	always_comb begin
		my_below  = cell_valid && (rend_q < cmd.new_begin);
		my_above  = cell_valid && (rbegin_q > cmd.new_end);
		my_hit    = cell_valid && (rbegin_q <= cmd.new_end) && (rend_q >= cmd.new_begin);
		hit_incl  = left.hit_seen | my_hit;
		first_hit = my_hit & ~left.hit_seen;
	end

	assign link.rbegin   = rbegin_q;
	assign link.rend     = rend_q;
	assign link.below    = my_below;
	assign link.above    = my_above;
	assign link.hit_seen = hit_incl;

	// Pull from the right on a removal; pull from the left or load the new range on an insert
	always_ff @(posedge clk) begin
		if (cmd.remove && hit_incl) begin
			rbegin_q <= right_begin;
			rend_q   <= right_end;
		end else if (cmd.insert) begin
			if (left.above) begin
				rbegin_q <= left.rbegin;
				rend_q   <= left.rend;
			end else if (left.below && !my_below) begin
				rbegin_q <= cmd.new_begin;
				rend_q   <= cmd.new_end;
			end
		end
	end

endmodule : rrt_cell

`default_nettype wire

/* sv/received_range_tracker_top.sv */
// Top level of the received range tracker: controller plus a chain of rrt_cell.
// Depends on rrt_pkg and rrt_cell.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------------
//   in      | in_valid / in_stall  | operation, range_start, range_length, size_value
//   out     | out_valid / out_stall| status, complete, range_count, file_size
//
// One item at a time. A raise_size item or a rejected add goes from evaluation
// straight to the result; an accepted add passes through the merge state, which
// removes the stored ranges it merges, one merged range per cycle, then inserts.
// Reset clears the range count and the file size; cell contents need no reset.
// A result waits in the output register while out_stall is high; the next item
// is taken as soon as the controller has returned to idle.
`default_nettype none

module received_range_tracker_top import rrt_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   operation,
	input  wire logic [OFFSET_BITS-1:0] range_start,
	input  wire logic [LENGTH_BITS-1:0] range_length,
	input  wire logic [OFFSET_BITS-1:0] size_value,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [1:0]                  status,
	output logic                        complete,
	output logic [COUNT_BITS-1:0]       range_count,
	output logic [OFFSET_BITS-1:0]      file_size
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EVAL  = 4'b0010,
		ST_MERGE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t  state_q;
	count_t  count_q;
	offset_t size_q;
	logic    out_valid_q;

	// Item registers
	logic    op_q;
	logic    ovf_q;
	offset_t s_q;
	offset_t e_q;
	offset_t size_in_q;
	status_t status_q;

	// Output registers
	status_t                 res_status_q;
	logic                    res_complete_q;
	logic [COUNT_BITS-1:0]   res_count_q;
	offset_t                 res_size_q;

	logic [SUM_BITS-1:0] sum;
	cell_cmd_t           cmd;
	cell_link_t          link [MAX_RANGES+1];
	logic [MAX_RANGES-1:0] first_hit;
	offset_t             fh_begin;
	offset_t             fh_end;
	logic                any_hit;
	logic                table_full;
	logic                in_xfer;
	logic                out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign sum      = SUM_BITS'(range_start) + SUM_BITS'(range_length);

	assign any_hit    = link[MAX_RANGES].hit_seen;
	assign table_full = (count_q == CNT_BITS'(MAX_RANGES));

	// Broadcast the working range and the shift command
	always_comb begin
		cmd.new_begin = s_q;
		cmd.new_end   = e_q;
		cmd.remove    = (state_q == ST_MERGE) && any_hit;
		cmd.insert    = (state_q == ST_MERGE) && !any_hit;
	end

	// The head of the chain sees an empty range below everything
	assign link[0] = '{rbegin: '0, rend: '0, below: 1'b1, above: 1'b0, hit_seen: 1'b0};

	for (genvar j = 0; j < MAX_RANGES; j++) begin : g_cell
		offset_t rb;
		offset_t re;
		if (j < MAX_RANGES - 1) begin : g_mid
			assign rb = link[j+2].rbegin;
			assign re = link[j+2].rend;
		end else begin : g_last
			assign rb = link[j+1].rbegin;
			assign re = link[j+1].rend;
		end
		rrt_cell u_cell (
			.clk        (clk),
			.cell_valid (count_q > CNT_BITS'(j)),
			.cmd        (cmd),
			.left       (link[j]),
			.right_begin(rb),
			.right_end  (re),
			.link       (link[j+1]),
			.first_hit  (first_hit[j])
		);
	end

	// Select the first overlapping range
	always_comb begin
		fh_begin = '0;
		fh_end   = '0;
		for (int j = 0; j < MAX_RANGES; j++) begin
			if (first_hit[j]) begin
				fh_begin = fh_begin | link[j+1].rbegin;
				fh_end   = fh_end | link[j+1].rend;
			end
		end
	end

	// Latch the item on transfer; widen the working range while merging
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q      <= operation;
			ovf_q     <= |sum[SUM_BITS-1:OFFSET_BITS];
			s_q       <= range_start;
			e_q       <= sum[OFFSET_BITS-1:0];
			size_in_q <= size_value;
		end else if (cmd.remove) begin
			if (fh_begin < s_q) begin
				s_q <= fh_begin;
			end
			if (fh_end > e_q) begin
				e_q <= fh_end;
			end
		end
	end

	// Sequence one item through evaluate, merge and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			size_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (op_q == OP_RAISE) begin
						if (size_in_q > size_q) begin
							size_q <= size_in_q;
						end
						state_q <= ST_DONE;
					end else if (ovf_q || (!any_hit && table_full)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (any_hit) begin
						count_q <= count_q - 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						if (e_q > size_q) begin
							size_q <= e_q;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Decide the status during evaluation
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			if (op_q == OP_RAISE) begin
				status_q <= STATUS_OK;
			end else if (ovf_q) begin
				status_q <= STATUS_OVERFLOW;
			end else if (!any_hit && table_full) begin
				status_q <= STATUS_FULL;
			end else begin
				status_q <= STATUS_OK;
			end
		end
	end

	// Hold the result until the output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			res_status_q   <= status_q;
			res_complete_q <= (count_q == CNT_BITS'(1)) && (link[1].rbegin == '0) &&
			                  (link[1].rend == size_q);
			res_count_q    <= COUNT_BITS'(count_q);
			res_size_q     <= size_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = res_status_q;
	assign complete    = res_complete_q;
	assign range_count = res_count_q;
	assign file_size   = res_size_q;

endmodule : received_range_tracker_top

`default_nettype wire

/* sv/rrt_checker.sv */
// Port-level checks for the received range tracker, bound to the top level.
// Depends on rrt_pkg and received_range_tracker_top.
`default_nettype none

module rrt_checker import rrt_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic [1:0]             status,
	input wire logic                   complete,
	input wire logic [COUNT_BITS-1:0]  range_count,
	input wire logic [OFFSET_BITS-1:0] file_size
);

	// A stalled result keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(range_count) &&
		$stable(file_size) && $stable(complete))
		else $error("stalled result changed");

	// One item at a time: the block is busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	// Complete means exactly one stored range
	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && complete |-> range_count == COUNT_BITS'(1))
		else $error("complete flag with range count other than one");

	// Only defined status codes appear
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STATUS_OK || status == STATUS_FULL ||
		status == STATUS_OVERFLOW)
		else $error("undefined status code");

endmodule : rrt_checker

bind received_range_tracker_top rrt_checker u_rrt_checker (.*);

`default_nettype wire

/* bench/tb_received_range_tracker_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for received_range_tracker_top: a queue-fed driver, a monitor, a range-table
// predictor and a watchdog. Depends on rrt_pkg and the tracker RTL only.

module tb_received_range_tracker_top;
	import rrt_pkg::*;

	localparam offset_t OFF_MASK       = '1;
	localparam int      IDLE_PCT       = 38;
	localparam int      STEADY_FROM    = 400;
	localparam int      STEADY_TO      = 550;
	localparam int      HOLD_AT        = 800;
	localparam int      HOLD_CYCLES    = 300;
	localparam int      WINDOW_ITEMS   = 1150;
	localparam int      NOISE_ITEMS    = 150;
	localparam int      WATCHDOG_LIMIT = 2000;
	localparam int      DRAIN_CYCLES   = 20;

	typedef struct {
		logic                   op;
		offset_t                start;
		logic [LENGTH_BITS-1:0] len;
		offset_t                size;
	} chunk_item_t;

	typedef struct packed {
		status_t               status;
		logic                  complete;
		logic [COUNT_BITS-1:0] count;
		offset_t               size;
	} tracker_report_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   operation = OP_ADD;
	logic [OFFSET_BITS-1:0] range_start = '0;
	logic [LENGTH_BITS-1:0] range_length = '0;
	logic [OFFSET_BITS-1:0] size_value = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [1:0]             status;
	logic                   complete;
	logic [COUNT_BITS-1:0]  range_count;
	logic [OFFSET_BITS-1:0] file_size;

	chunk_item_t     queued_items[$];
	chunk_item_t     on_wire;
	tracker_report_t expected_reports[$];

	// Predicted range table
	offset_t tbl_begin[MAX_RANGES];
	offset_t tbl_end[MAX_RANGES];
	int      tbl_count = 0;
	offset_t tbl_size = '0;

	int error_count    = 0;
	int accepted_items = 0;
	int results_seen   = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;
	int quiet_cycles   = 0;

	received_range_tracker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.range_start  (range_start),
		.range_length (range_length),
		.size_value   (size_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.complete     (complete),
		.range_count  (range_count),
		.file_size    (file_size)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	function automatic offset_t rand_offset();
		return offset_t'({$urandom, $urandom});
	endfunction

	task automatic push_add(input offset_t start, input logic [LENGTH_BITS-1:0] len);
		chunk_item_t it;
		it.op = OP_ADD;
		it.start = start;
		it.len = len;
		it.size = rand_offset();
		queued_items.push_back(it);
	endtask

	task automatic push_raise(input offset_t size);
		chunk_item_t it;
		it.op = OP_RAISE;
		it.start = rand_offset();
		it.len = $urandom;
		it.size = size;
		queued_items.push_back(it);
	endtask

	// End lands past the offset range: the high start bits are all ones
	task automatic push_overflow();
		push_add(OFF_MASK - offset_t'($urandom_range(0, 1000)), $urandom | 32'h0000_0400);
	endtask

	// Apply one transfer to the predicted table and queue the report it should produce
	task automatic update_range_table(input chunk_item_t it);
		logic [SUM_BITS-1:0] span_sum;
		offset_t             lo, hi;
		offset_t             nb[MAX_RANGES+1];
		offset_t             ne[MAX_RANGES+1];
		int                  n, hits;
		bit                  placed;
		tracker_report_t     rep;
		rep.status = STATUS_OK;
		if (it.op == OP_ADD) begin
			span_sum = SUM_BITS'(it.start) + SUM_BITS'(it.len);
			if (span_sum > SUM_BITS'(OFF_MASK)) begin
				rep.status = STATUS_OVERFLOW;
			end else begin
				lo = it.start;
				hi = offset_t'(span_sum);
				hits = 0;
				for (int i = 0; i < tbl_count; i++)
					if (tbl_begin[i] <= hi && tbl_end[i] >= lo)
						hits++;
				if (hits == 0 && tbl_count >= MAX_RANGES) begin
					rep.status = STATUS_FULL;
				end else begin
					// Rebuild the sorted table, folding every touched range into lo..hi
					n = 0;
					placed = 1'b0;
					for (int i = 0; i < tbl_count; i++) begin
						if (tbl_end[i] < lo) begin
							nb[n] = tbl_begin[i];
							ne[n] = tbl_end[i];
							n++;
						end else if (tbl_begin[i] > hi) begin
							if (!placed) begin
								nb[n] = lo;
								ne[n] = hi;
								n++;
								placed = 1'b1;
							end
							nb[n] = tbl_begin[i];
							ne[n] = tbl_end[i];
							n++;
						end else begin
							if (tbl_begin[i] < lo)
								lo = tbl_begin[i];
							if (tbl_end[i] > hi)
								hi = tbl_end[i];
						end
					end
					if (!placed) begin
						nb[n] = lo;
						ne[n] = hi;
						n++;
					end
					if (n > MAX_RANGES)
						n = MAX_RANGES;
					for (int i = 0; i < n; i++) begin
						tbl_begin[i] = nb[i];
						tbl_end[i] = ne[i];
					end
					tbl_count = n;
					if (hi > tbl_size)
						tbl_size = hi;
				end
			end
		end else if (it.size > tbl_size) begin
			tbl_size = it.size;
		end
		rep.complete = (tbl_count == 1 && tbl_begin[0] == '0 && tbl_end[0] == tbl_size);
		rep.count = COUNT_BITS'(tbl_count);
		rep.size = tbl_size;
		expected_reports.push_back(rep);
	endtask

	// Driver: predict on each input transfer, then present the next item or idle
	always @(posedge clk) begin : driver
		chunk_item_t nxt;
		bit          steady;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				update_range_table(on_wire);
				accepted_items++;
			end
			if (!in_valid || !in_stall) begin
				steady = accepted_items >= STEADY_FROM && accepted_items < STEADY_TO;
				if (queued_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					nxt = queued_items.pop_front();
					on_wire = nxt;
					operation <= nxt.op;
					range_start <= nxt.start;
					range_length <= nxt.len;
					size_value <= nxt.size;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each output transfer, then pick the next stall value
	always @(posedge clk) begin : monitor
		tracker_report_t want;
		bit              steady;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_reports.size() == 0) begin
					report_error($sformatf("unexpected result: status %0d count %0d size %0h",
						status, range_count, file_size));
				end else begin
					want = expected_reports.pop_front();
					if (status !== want.status)
						report_error($sformatf("status got %0d want %0d", status, want.status));
					if (complete !== want.complete)
						report_error($sformatf("complete got %0b want %0b", complete,
							want.complete));
					if (range_count !== want.count)
						report_error($sformatf("range_count got %0d want %0d", range_count,
							want.count));
					if (file_size !== want.size)
						report_error($sformatf("file_size got %0h want %0h", file_size,
							want.size));
				end
			end
			steady = results_seen >= STEADY_FROM && results_seen < STEADY_TO;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_seen == HOLD_AT && !hold_done) begin
				// Long hold-off so the block backs up and stalls its input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && $urandom_range(99) < IDLE_PCT;
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin : sequencer
		int unsigned main_end, win_lo, win_hi, last_end, fs, room, fl;
		int          nfrag, pick;

		// Assert reset once every process waits on its edge, so the falling edge is seen
		arst_n <= 1'b0;

		// Directed: fill the table, hit table full, merge by touching, swallow all
		push_raise('0);
		push_add('0, '0);
		for (int i = 1; i <= 15; i++)
			push_add(offset_t'(10 * i), 2);
		push_add(1000, 3);
		push_add(12, 0);
		push_add(2, 8);
		push_add(0, 200);
		push_raise(300);
		push_add(200, 100);
		push_add(OFF_MASK, '1);
		queued_items.push_back('{OP_RAISE, OFF_MASK, '1, offset_t'(5)});

		// Windows above the covered prefix: fragments, then a bridge that merges them all
		main_end = 300;
		while (queued_items.size() < WINDOW_ITEMS) begin
			win_lo = main_end + $urandom_range(1, 64);
			win_hi = win_lo + $urandom_range(16, 1024);
			nfrag = $urandom_range(1, 20);
			last_end = win_lo;
			for (int k = 0; k < nfrag; k++) begin
				pick = $urandom_range(11);
				if (pick == 0) begin
					push_overflow();
				end else if (pick < 3) begin
					push_raise(offset_t'(win_lo + $urandom_range(0, win_hi - win_lo)));
				end else begin
					fs = ($urandom_range(3) == 0) ? last_end
						: win_lo + $urandom_range(0, win_hi - win_lo);
					room = win_hi - fs;
					fl = ($urandom_range(3) == 0) ? $urandom_range(0, room)
						: $urandom_range(0, (room < 40) ? room : 40);
					push_add(offset_t'(fs), fl);
					last_end = fs + fl;
				end
			end
			push_add(offset_t'(main_end), win_hi - main_end);
			main_end = win_hi;
			if ($urandom_range(1))
				push_raise(offset_t'(win_hi + $urandom_range(0, 3)));
		end

		// Noise: full-width fields, scattered ranges, top-of-range ends
		push_add(OFF_MASK, '0);
		push_add(OFF_MASK - 5, 5);
		for (int k = 0; k < NOISE_ITEMS; k++) begin
			if ($urandom_range(1))
				push_raise($urandom_range(1) ? rand_offset() : offset_t'($urandom_range(0, 1 << 20)));
			else
				push_add($urandom_range(1) ? rand_offset() : offset_t'($urandom_range(0, 1 << 20)),
					$urandom_range(1) ? $urandom : $urandom_range(0, 64));
		end
		push_raise(OFF_MASK);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (queued_items.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_reports.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_reports.size()));

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
